### sv/bfa_pkg.sv
// Shared types and constants for the bitmap first-fit allocator.
// Used by bfa_front, bfa_back and the top module; depends on nothing.
package bfa_pkg;

   localparam int CNT_W = 16;
   localparam int NUM_W = 18;
   localparam int GRP_W = 3;
   localparam int CSR_IDX_W = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE = 1'b1;

   localparam logic POOL_BLOCK = 1'b0;
   localparam logic POOL_INODE = 1'b1;

   localparam logic ST_OK = 1'b0;
   localparam logic ST_FULL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCKS_PER_GROUP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INODES_PER_GROUP = 2'd1;

   localparam logic [CNT_W-1:0] BLOCKS_RESET = 16'd32768;
   localparam logic [CNT_W-1:0] INODES_RESET = 16'd8192;

   typedef struct packed {
      logic             opcode;
      logic             pool;
      logic [GRP_W-1:0] group;
      logic [NUM_W-1:0] item;
      logic             grp_ok;
   } entry_type;

endpackage

### sv/bfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bfa_front.sv
// Front end of the allocator: takes request transactions, classifies them and
// holds them in a two-entry queue for the back end. Depends on bfa_pkg.
module bfa_front #(
   parameter int NUM_GROUPS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         hold,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic                         req_pool,
   input  logic [bfa_pkg::GRP_W-1:0]    req_group,
   input  logic [bfa_pkg::NUM_W-1:0]    req_item_number,
   output logic                         q_valid,
   output bfa_pkg::entry_type           q_entry,
   input  logic                         q_pop
);

   bfa_pkg::entry_type ent0_ff, ent0_in, ent1_ff, ent1_in, new_ent;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req_ready = (cnt_ff != 2'd2) && !hold;
   assign push = req_valid && req_ready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_entry = ent0_ff;

   always_comb begin
      new_ent.opcode = req_opcode;
      new_ent.pool = req_pool;
      new_ent.group = req_group;
      new_ent.item = req_item_number;
      new_ent.grp_ok = (9'(req_group) < 9'(NUM_GROUPS));
   end

   always_comb begin
      ent0_in = ent0_ff;
      ent1_in = ent1_ff;
      cnt_in = cnt_ff;
      if (q_pop) begin
         ent0_in = ent1_ff;
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         if (cnt_in == 2'd0) begin
            ent0_in = new_ent;
         end else begin
            ent1_in = new_ent;
         end
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

endmodule

### sv/bfa_back.sv
// Back end of the allocator: clears the bitmaps after reset, scans for the
// first free bit, runs the modulo for frees and updates the bitmap RAM.
// Depends on bfa_pkg and bfa_ram.
module bfa_back #(
   parameter int BITMAP_BITS = 32768,
   parameter int NUM_GROUPS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bfa_pkg::CNT_W-1:0]    blocks_per_group,
   input  logic [bfa_pkg::CNT_W-1:0]    inodes_per_group,
   input  logic                         q_valid,
   input  bfa_pkg::entry_type           q_entry,
   output logic                         q_pop,
   output logic                         clearing,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_status,
   output logic [bfa_pkg::NUM_W-1:0]    rsp_allocated_number
);

   localparam int WPG = (BITMAP_BITS + 63) / 64;
   localparam int WW = (WPG > 1) ? $clog2(WPG) : 1;
   localparam int WCW = $clog2(WPG + 1);
   localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int AW = 1 + GW + WW;
   localparam int DEPTH = 1 << AW;
   localparam int TAIL = BITMAP_BITS % 64;
   localparam int BW = WW + 6;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_SCAN = 4'd2;
   localparam logic [3:0] S_AWRITE = 4'd3;
   localparam logic [3:0] S_MUL = 4'd4;
   localparam logic [3:0] S_DIV = 4'd5;
   localparam logic [3:0] S_FREAD = 4'd6;
   localparam logic [3:0] S_FWAIT = 4'd7;

   logic [3:0] state_ff, state_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   bfa_pkg::entry_type cur_ff, cur_in;
   logic [bfa_pkg::CNT_W-1:0] count_ff, count_in;
   logic [WCW-1:0] rd_w_ff, rd_w_in;
   logic chk_valid_ff, chk_valid_in;
   logic [WW-1:0] chk_w_ff, chk_w_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [63:0] word_ff, word_in;
   logic [bfa_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [bfa_pkg::NUM_W-1:0] dvd_ff, dvd_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_status_ff, rsp_status_in;
   logic [bfa_pkg::NUM_W-1:0] rsp_num_ff, rsp_num_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [63:0] wr_data, rd_data;
   logic [GW-1:0] grp_idx;
   logic [63:0] usable, freebits;
   logic [5:0] pos6;
   logic [16:0] rem_w, divisor;

   bfa_ram #(
      .WIDTH(64),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign grp_idx = GW'(cur_ff.group);
   assign clearing = (state_ff == S_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_allocated_number = rsp_num_ff;

   always_comb begin
      usable = {64{1'b1}};
      if ((TAIL != 0) && (32'(chk_w_ff) == WPG - 1)) begin
         usable = (64'd1 << TAIL) - 64'd1;
      end
      freebits = ~rd_data & usable;
      pos6 = 6'd0;
      for (int i = 63; i >= 0; i--) begin
         if (freebits[i]) begin
            pos6 = 6'(i);
         end
      end
      divisor = (count_ff == '0) ? 17'd1 : {1'b0, count_ff};
      rem_w = {rem_ff, dvd_ff[bfa_pkg::NUM_W-1]};
   end

   always_comb begin
      state_in = state_ff;
      clr_addr_in = clr_addr_ff;
      cur_in = cur_ff;
      count_in = count_ff;
      rd_w_in = rd_w_ff;
      chk_valid_in = 1'b0;
      chk_w_in = chk_w_ff;
      bit_in = bit_ff;
      word_in = word_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      div_cnt_in = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_num_in = rsp_num_ff;
      q_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = {cur_ff.pool, grp_idx, bit_ff[BW-1:6]};
      wr_data = word_ff;
      rd_addr = {cur_ff.pool, grp_idx, bit_ff[BW-1:6]};
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == {AW{1'b1}}) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop = 1'b1;
               cur_in = q_entry;
               count_in = (q_entry.pool == bfa_pkg::POOL_INODE) ? inodes_per_group
                                                                : blocks_per_group;
               rd_w_in = '0;
               rem_in = '0;
               dvd_in = q_entry.item;
               div_cnt_in = '0;
               if (!q_entry.grp_ok) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = (q_entry.opcode == bfa_pkg::OP_ALLOC) ? bfa_pkg::ST_FULL
                                                                        : bfa_pkg::ST_OK;
                  rsp_num_in = '0;
               end else if (q_entry.opcode == bfa_pkg::OP_ALLOC) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DIV;
               end
            end
         end
         S_SCAN: begin
            rd_addr = {cur_ff.pool, grp_idx, rd_w_ff[WW-1:0]};
            if (32'(rd_w_ff) < WPG) begin
               rd_w_in = rd_w_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_w_in = rd_w_ff[WW-1:0];
            end
            if (chk_valid_ff) begin
               if (freebits != '0) begin
                  bit_in = {chk_w_ff, pos6};
                  word_in = rd_data | (64'd1 << pos6);
                  chk_valid_in = 1'b0;
                  state_in = S_AWRITE;
               end else if (32'(chk_w_ff) == WPG - 1) begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = bfa_pkg::ST_FULL;
                  rsp_num_in = '0;
                  chk_valid_in = 1'b0;
                  state_in = S_IDLE;
               end
            end
         end
         S_AWRITE: begin
            wr_en = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = bfa_pkg::ST_OK;
            rsp_num_in = bfa_pkg::NUM_W'(20'(cur_ff.group) * 20'(count_ff) + 20'(bit_ff));
            state_in = S_IDLE;
         end
         S_DIV: begin
            dvd_in = {dvd_ff[bfa_pkg::NUM_W-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 5'd1;
            if (rem_w >= divisor) begin
               rem_in = bfa_pkg::CNT_W'(rem_w - divisor);
            end else begin
               rem_in = bfa_pkg::CNT_W'(rem_w);
            end
            if (div_cnt_ff == 5'(bfa_pkg::NUM_W - 1)) begin
               bit_in = BW'(rem_in);
               if (17'(rem_in) < 17'(BITMAP_BITS)) begin
                  state_in = S_FREAD;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_status_in = bfa_pkg::ST_OK;
                  rsp_num_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         S_FREAD: begin
            state_in = S_FWAIT;
         end
         S_FWAIT: begin
            wr_en = 1'b1;
            wr_data = rd_data & ~(64'd1 << bit_ff[5:0]);
            rsp_valid_in = 1'b1;
            rsp_status_in = bfa_pkg::ST_OK;
            rsp_num_in = '0;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_addr_ff <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      count_ff <= count_in;
      rd_w_ff <= rd_w_in;
      chk_w_ff <= chk_w_in;
      bit_ff <= bit_in;
      word_ff <= word_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_cnt_ff <= div_cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_num_ff <= rsp_num_in;
   end

endmodule

### sv/bitmap_first_fit_allocator.sv
// Bitmap first-fit allocator: block and inode bitmaps per group in one RAM.
// After reset the RAM is cleared one word per cycle, all 2 << (clog2(groups) +
// clog2(words per group)) words (8192 at the default sizes), during which no
// transaction is taken. An allocate reads the group's 64-bit words one per
// cycle until it finds a free bit or the group's last word; a free runs an
// 18-bit bit-serial modulo and, when the remainder lies inside the bitmap, a
// read-modify-write.
// Depends on bfa_pkg, bfa_front, bfa_back and bfa_ram.
module bitmap_first_fit_allocator #(
   parameter int BITMAP_BITS = 32768,
   parameter int NUM_GROUPS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic                          req_pool,
   input  logic [bfa_pkg::GRP_W-1:0]     req_group,
   input  logic [bfa_pkg::NUM_W-1:0]     req_item_number,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_status,
   output logic [bfa_pkg::NUM_W-1:0]     rsp_allocated_number,
   input  logic                          csr_wr_en,
   input  logic [bfa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bfa_pkg::CNT_W-1:0]     csr_wr_data
);

   logic [bfa_pkg::CNT_W-1:0] blocks_ff, inodes_ff;
   logic q_valid, q_pop, clearing;
   bfa_pkg::entry_type q_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= bfa_pkg::BLOCKS_RESET;
         inodes_ff <= bfa_pkg::INODES_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == bfa_pkg::CSR_BLOCKS_PER_GROUP) begin
            blocks_ff <= csr_wr_data;
         end
         if (csr_index == bfa_pkg::CSR_INODES_PER_GROUP) begin
            inodes_ff <= csr_wr_data;
         end
      end
   end

   bfa_front #(
      .NUM_GROUPS(NUM_GROUPS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .hold(clearing),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_pool(req_pool),
      .req_group(req_group),
      .req_item_number(req_item_number),
      .q_valid(q_valid),
      .q_entry(q_entry),
      .q_pop(q_pop)
   );

   bfa_back #(
      .BITMAP_BITS(BITMAP_BITS),
      .NUM_GROUPS(NUM_GROUPS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .blocks_per_group(blocks_ff),
      .inodes_per_group(inodes_ff),
      .q_valid(q_valid),
      .q_entry(q_entry),
      .q_pop(q_pop),
      .clearing(clearing),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_allocated_number(rsp_allocated_number)
   );

endmodule

### tb/sv/tb_bitmap_first_fit_allocator.sv
// Self-checking testbench for bitmap_first_fit_allocator: a bit-accurate
// predictor of both per-group bitmaps checks every response in order.
// Depends on bfa_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb_bitmap_first_fit_allocator;

   localparam int BITMAP_BITS = 32768;
   localparam int NUM_GROUPS = 8;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [bfa_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [bfa_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic                      status;
      logic [bfa_pkg::NUM_W-1:0] number;
   } alloc_result_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic                          req_opcode = bfa_pkg::OP_ALLOC;
   logic                          req_pool = bfa_pkg::POOL_BLOCK;
   logic [bfa_pkg::GRP_W-1:0]     req_group = '0;
   logic [bfa_pkg::NUM_W-1:0]     req_item_number = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_status;
   logic [bfa_pkg::NUM_W-1:0]     rsp_allocated_number;
   logic                          csr_wr_en = 1'b0;
   logic [bfa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [bfa_pkg::CNT_W-1:0]     csr_wr_data = '0;

   bit [BITMAP_BITS-1:0]      used_map [2][NUM_GROUPS];
   bit [bfa_pkg::CNT_W-1:0]   blocks_cnt = bfa_pkg::BLOCKS_RESET;
   bit [bfa_pkg::CNT_W-1:0]   inodes_cnt = bfa_pkg::INODES_RESET;
   alloc_result_type          pending_q [$];
   bit                        no_idle = 1'b0;
   int                        error_count = 0;
   int                        alloc_count = 0;
   int                        free_count = 0;
   int                        csr_count = 0;
   int                        checked_count = 0;
   longint                    cycle_count = 0;

   bitmap_first_fit_allocator #(
      .BITMAP_BITS(BITMAP_BITS),
      .NUM_GROUPS(NUM_GROUPS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_pool(req_pool),
      .req_group(req_group),
      .req_item_number(req_item_number),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_allocated_number(rsp_allocated_number),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= 38);
   end

   // Updates the bitmap copy for one request and returns the response it gives.
   function automatic alloc_result_type bitmap_update(logic op, logic pool,
                                                      logic [bfa_pkg::GRP_W-1:0] grp,
                                                      logic [bfa_pkg::NUM_W-1:0] item);
      alloc_result_type res;
      bit [bfa_pkg::CNT_W-1:0] count;
      int unsigned div;
      int unsigned offset;
      int found;
      count = pool ? inodes_cnt : blocks_cnt;
      res.status = bfa_pkg::ST_OK;
      res.number = '0;
      if (op == bfa_pkg::OP_ALLOC) begin
         found = -1;
         for (int b = 0; b < BITMAP_BITS; b++) begin
            if (!used_map[pool][grp][b]) begin
               found = b;
               break;
            end
         end
         if (found < 0) begin
            res.status = bfa_pkg::ST_FULL;
         end else begin
            used_map[pool][grp][found] = 1'b1;
            res.number = bfa_pkg::NUM_W'(32'(grp) * 32'(count) + 32'(found));
         end
      end else begin
         div = (count == 0) ? 1 : 32'(count);
         offset = 32'(item) % div;
         if (offset < BITMAP_BITS) used_map[pool][grp][offset] = 1'b0;
      end
      return res;
   endfunction

   task automatic send_request(logic op, logic pool, logic [bfa_pkg::GRP_W-1:0] grp,
                               logic [bfa_pkg::NUM_W-1:0] item);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_pool <= pool;
      req_group <= grp;
      req_item_number <= item;
      do @(posedge clock); while (!req_ready);
      pending_q.push_back(bitmap_update(op, pool, grp, item));
      if (op == bfa_pkg::OP_ALLOC) alloc_count++;
      else free_count++;
      if (!no_idle && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic [bfa_pkg::CSR_IDX_W-1:0] idx,
                            logic [bfa_pkg::CNT_W-1:0] data);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == bfa_pkg::CSR_BLOCKS_PER_GROUP) blocks_cnt = data;
      else if (idx == bfa_pkg::CSR_INODES_PER_GROUP) inodes_cnt = data;
      csr_count++;
   endtask

   always @(posedge clock) begin
      alloc_result_type exp_res;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            $display("%0t: response with nothing expected, status %0b number %0d",
                     $time, rsp_status, rsp_allocated_number);
            error_count++;
         end else begin
            exp_res = pending_q.pop_front();
            checked_count++;
            if (rsp_status !== exp_res.status) begin
               $display("%0t: status expected %0b actual %0b",
                        $time, exp_res.status, rsp_status);
               error_count++;
            end
            if (rsp_allocated_number !== exp_res.number) begin
               $display("%0t: allocated_number expected %0d actual %0d",
                        $time, exp_res.number, rsp_allocated_number);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_defaults();
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_BLOCK, 3'd0, '0);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_INODE, 3'd7, '1);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_BLOCK, 3'd7, 18'h2AAAA);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_BLOCK, 3'd0, 18'h15555);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_BLOCK, 3'd0, '0);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_BLOCK, 3'd0, '0);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_BLOCK, 3'd0, '0);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_BLOCK, 3'd7, '1);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_INODE, 3'd7, 18'd57344);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_INODE, 3'd7, '0);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_INODE, 3'd5, 18'h2AAAA);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_BLOCK, 3'd2, 18'h15555);
   endtask

   task automatic test_count_extremes();
      write_csr(bfa_pkg::CSR_BLOCKS_PER_GROUP, '0);
      write_csr(bfa_pkg::CSR_INODES_PER_GROUP, 16'hFFFF);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_BLOCK, 3'd6, '0);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_BLOCK, 3'd6, 18'd1);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_INODE, 3'd7, '0);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_INODE, 3'd7, '0);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_INODE, 3'd7, 18'd40000);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_INODE, 3'd7, 18'd65536);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_INODE, 3'd7, '0);
      write_csr(bfa_pkg::CSR_BLOCKS_PER_GROUP, 16'd1);
      write_csr(bfa_pkg::CSR_INODES_PER_GROUP, 16'd1);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_BLOCK, 3'd0, '1);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_BLOCK, 3'd0, '0);
      send_request(bfa_pkg::OP_FREE, bfa_pkg::POOL_INODE, 3'd7, 18'h2AAAA);
      write_csr(CSR_SPARE_LO, 16'd5);
      write_csr(CSR_SPARE_HI, 16'hFFFF);
      send_request(bfa_pkg::OP_ALLOC, bfa_pkg::POOL_INODE, 3'd4, '0);
      write_csr(bfa_pkg::CSR_BLOCKS_PER_GROUP, bfa_pkg::BLOCKS_RESET);
      write_csr(bfa_pkg::CSR_INODES_PER_GROUP, bfa_pkg::INODES_RESET);
   endtask

   task automatic test_random_traffic(int items, bit burst);
      logic op, pool;
      logic [bfa_pkg::GRP_W-1:0] grp;
      logic [bfa_pkg::NUM_W-1:0] item;
      int unsigned count, pick;
      no_idle = burst;
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(99);
         pool = 1'($urandom_range(1));
         grp = (pick < 70) ? bfa_pkg::GRP_W'($urandom_range(1))
                           : bfa_pkg::GRP_W'($urandom_range(7));
         count = pool ? 32'(inodes_cnt) : 32'(blocks_cnt);
         item = bfa_pkg::NUM_W'($urandom);
         if (pick < 50) begin
            op = bfa_pkg::OP_ALLOC;
         end else begin
            op = bfa_pkg::OP_FREE;
            if (pick < 82) begin
               item = bfa_pkg::NUM_W'($urandom_range(7) * count + $urandom_range(200));
            end
         end
         send_request(op, pool, grp, item);
      end
      no_idle = 1'b0;
   endtask

   task automatic test_config_phases();
      bit [bfa_pkg::CNT_W-1:0] picks [6] = '{16'd1, 16'd64, 16'd1000, 16'd32768,
                                             16'hFFFF, 16'd8192};
      for (int p = 0; p < 4; p++) begin
         write_csr(bfa_pkg::CSR_BLOCKS_PER_GROUP,
                   (p == 3) ? bfa_pkg::CNT_W'($urandom) : picks[$urandom_range(5)]);
         write_csr(bfa_pkg::CSR_INODES_PER_GROUP,
                   (p == 2) ? bfa_pkg::CNT_W'($urandom) : picks[$urandom_range(5)]);
         test_random_traffic(200, p == 1);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_count_extremes();
      test_config_phases();
      test_random_traffic(50, 1'b0);
      wait_idle();
      $display("Covered %0d allocations, %0d frees and %0d register writes;",
               alloc_count, free_count, csr_count);
      $display("%0d responses checked, %0d errors.", checked_count, error_count);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
